@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bus decoder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("bus decoder check failed");

`endif

@@ rtl/core/hcmm_pkg.sv @@
// Types, constants and the boot image of the console bus decoder.
`timescale 1ns / 1ps

package hcmm_pkg;

    // Shared byte memory: work RAM, then sprite table, then high RAM
    localparam int MEM_AW    = 14;
    localparam int MEM_DEPTH = 8576;
    localparam logic [MEM_AW-1:0] SPRITE_BASE = 14'd8192;
    localparam logic [MEM_AW-1:0] FAST_BASE   = 14'd8448;
    localparam logic [MEM_AW-1:0] MEM_LAST    = 14'd8575;

    // Target unit codes
    localparam logic [2:0] UNIT_INTERNAL = 3'd0;
    localparam logic [2:0] UNIT_CART     = 3'd1;
    localparam logic [2:0] UNIT_JOYPAD   = 3'd2;
    localparam logic [2:0] UNIT_SERIAL   = 3'd3;
    localparam logic [2:0] UNIT_TIMER    = 3'd4;

    // Register values
    localparam logic [7:0] IRQ_FORCE  = 8'hE0;
    localparam logic [7:0] IF_RESET   = 8'hE1;
    localparam logic [7:0] IE_RESET   = 8'hFF;
    localparam logic [7:0] BOOT_RESET = 8'h00;
    localparam logic [7:0] OPEN_BUS   = 8'hFF;
    localparam logic [7:0] VIDEO_BYTE = 8'h00;

    // Fixed addresses
    localparam logic [15:0] ADDR_JOYPAD   = 16'hFF00;
    localparam logic [15:0] ADDR_SER_DATA = 16'hFF01;
    localparam logic [15:0] ADDR_SER_CTRL = 16'hFF02;
    localparam logic [15:0] ADDR_IF       = 16'hFF0F;
    localparam logic [15:0] ADDR_BOOT_OFF = 16'hFF50;
    localparam logic [15:0] ADDR_IE       = 16'hFFFF;

    typedef struct packed {
        logic        opcode;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  external_read_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] target_unit;
    } rsp_t;

    // Decoded access, from the decoder to the top level
    typedef struct packed {
        logic              is_write;
        logic [2:0]        unit;
        logic              use_mem;
        logic [7:0]        imm;
        logic              mem_we;
        logic [MEM_AW-1:0] mem_idx;
        logic              wr_if;
        logic              wr_ie;
        logic              wr_boot;
    } dec_t;

    // Memory access request
    typedef struct packed {
        logic              re;
        logic              we;
        logic [MEM_AW-1:0] idx;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef enum logic {
        MEM_CLEAR,
        MEM_READY
    } mem_state_t;

    localparam logic [7:0] BOOT_ROM [256] = '{
        8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
        8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
        8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
        8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
        8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
        8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
        8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
        8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
        8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
        8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
        8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
        8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
        8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
        8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
        8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
        8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
        8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hE2, 8'hF0, 8'h42,
        8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
        8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
        8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
        8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
        8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h3C,
        8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
        8'hBE, 8'h00, 8'h00, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
        8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
        8'hFB, 8'h86, 8'h00, 8'h00, 8'h3E, 8'h01, 8'hE0, 8'h50
    };

endpackage

@@ rtl/core/hcmm_decode.sv @@
// Address decoder: maps one bus beat onto a region, target unit and memory index.
`timescale 1ns / 1ps

module hcmm_decode (
    input  hcmm_pkg::req_t req,
    input  logic [7:0]     boot_off,
    input  logic [7:0]     if_val,
    input  logic [7:0]     ie_val,
    output hcmm_pkg::dec_t dec
);

    logic [15:0] a;
    logic        wr;

    assign a  = req.address;
    assign wr = req.opcode;

    // Walk the map in priority order
    always_comb
    begin
        dec          = '0;
        dec.is_write = wr;
        dec.unit     = hcmm_pkg::UNIT_INTERNAL;
        dec.imm      = hcmm_pkg::OPEN_BUS;
        dec.mem_idx  = {1'b0, a[12:0]};
        if (a[15:8] == 8'h00 && boot_off == 8'h00)
        begin
            // boot overlay: writes dropped
            dec.imm = hcmm_pkg::BOOT_ROM[a[7:0]];
        end
        else if (!a[15] || a[15:13] == 3'b101)
        begin
            dec.unit = hcmm_pkg::UNIT_CART;
            dec.imm  = req.external_read_data;
        end
        else if (a[15:13] == 3'b100)
        begin
            dec.imm = hcmm_pkg::VIDEO_BYTE;
        end
        else if (a < 16'hFE00)
        begin
            // work RAM and its echo
            dec.use_mem = 1'b1;
            dec.mem_we  = wr;
            dec.mem_idx = {1'b0, a[12:0]};
        end
        else if (a < 16'hFEA0)
        begin
            dec.use_mem = 1'b1;
            dec.mem_we  = wr;
            dec.mem_idx = hcmm_pkg::SPRITE_BASE + {6'd0, a[7:0]};
        end
        else if (a < 16'hFF00)
        begin
            dec.imm = hcmm_pkg::OPEN_BUS;
        end
        else if (a == hcmm_pkg::ADDR_JOYPAD)
        begin
            dec.unit = hcmm_pkg::UNIT_JOYPAD;
            dec.imm  = req.external_read_data;
        end
        else if (a == hcmm_pkg::ADDR_SER_DATA || a == hcmm_pkg::ADDR_SER_CTRL)
        begin
            dec.unit = hcmm_pkg::UNIT_SERIAL;
            dec.imm  = req.external_read_data;
        end
        else if (a[15:2] == 14'h3FC1)
        begin
            // FF04 through FF07
            dec.unit = hcmm_pkg::UNIT_TIMER;
            dec.imm  = req.external_read_data;
        end
        else if (a == hcmm_pkg::ADDR_IF)
        begin
            dec.wr_if = wr;
            dec.imm   = if_val;
        end
        else if (a >= 16'hFF40 && a <= 16'hFF4B)
        begin
            dec.imm = hcmm_pkg::VIDEO_BYTE;
        end
        else if (a == hcmm_pkg::ADDR_BOOT_OFF)
        begin
            dec.wr_boot = wr;
            dec.imm     = boot_off;
        end
        else if (a < 16'hFF80)
        begin
            dec.imm = hcmm_pkg::OPEN_BUS;
        end
        else if (a != hcmm_pkg::ADDR_IE)
        begin
            // high RAM
            dec.use_mem = 1'b1;
            dec.mem_we  = wr;
            dec.mem_idx = hcmm_pkg::FAST_BASE + {7'd0, a[6:0]};
        end
        else
        begin
            dec.wr_ie = wr;
            dec.imm   = ie_val;
        end
    end

endmodule

@@ rtl/core/hcmm_mem.sv @@
// Shared byte memory with a registered read port and a zeroing sweep after reset.
`timescale 1ns / 1ps

module hcmm_mem (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hcmm_pkg::mem_req_t   req,
    output logic [7:0]           rdata,
    output logic                 ready
);

    logic [7:0] mem [hcmm_pkg::MEM_DEPTH];
    logic [7:0] rdata_reg;

    hcmm_pkg::mem_state_t          state_reg, state_next;
    logic [hcmm_pkg::MEM_AW-1:0]   clr_idx_reg, clr_idx_next;

    logic                          wr_en;
    logic [hcmm_pkg::MEM_AW-1:0]   wr_idx;
    logic [7:0]                    wr_data;

    // Next state: sweep every entry once, then serve the bus
    always_comb
    begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        unique case (state_reg)
            hcmm_pkg::MEM_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == hcmm_pkg::MEM_LAST)
                begin
                    state_next = hcmm_pkg::MEM_READY;
                end
            end
            hcmm_pkg::MEM_READY:
            begin
                state_next = hcmm_pkg::MEM_READY;
            end
            default:
            begin
                state_next = hcmm_pkg::MEM_CLEAR;
            end
        endcase
    end

    // Outputs: pick the write port source
    always_comb
    begin
        ready   = 1'b0;
        wr_en   = 1'b0;
        wr_idx  = req.idx;
        wr_data = req.wdata;
        unique case (state_reg)
            hcmm_pkg::MEM_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_idx  = clr_idx_reg;
                wr_data = 8'h00;
            end
            hcmm_pkg::MEM_READY:
            begin
                ready = 1'b1;
                wr_en = req.we;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hcmm_pkg::MEM_CLEAR;
            clr_idx_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // Storage array: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.idx];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/handheld_console_memory_map_top.sv @@
// Top level of the handheld console memory map and bus decoder.
//
// One byte access enters per req beat and leaves one rsp beat carrying the read byte
// (0 for writes) and the target unit code. After reset the block zeroes its 8576-entry
// byte memory (work RAM, sprite table and high RAM), one entry per cycle, and holds
// req_ready low until the sweep is done. It then accepts one beat per cycle while rsp
// is not stalled; each beat is held in stage one, beside the registered memory read,
// and then in the response register. A stalled rsp holds at most one more beat inside
// the block.
`timescale 1ns / 1ps

module handheld_console_memory_map_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  hcmm_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output hcmm_pkg::rsp_t  rsp
);

    hcmm_pkg::dec_t     dec;
    hcmm_pkg::mem_req_t mem_req;
    logic [7:0]         mem_rdata;
    logic               mem_ready;
    logic               accept;
    logic               s1_adv;

    logic [7:0] boot_off_reg, if_reg, ie_reg;

    logic       s1_valid_reg, s1_valid_next;
    logic       s1_write_reg;
    logic [2:0] s1_unit_reg;
    logic       s1_mem_reg;
    logic [7:0] s1_imm_reg;

    logic            out_valid_reg, out_valid_next;
    hcmm_pkg::rsp_t  rsp_reg, rsp_next;

    hcmm_decode u_decode (
        .req      (req),
        .boot_off (boot_off_reg),
        .if_val   (if_reg),
        .ie_val   (ie_reg),
        .dec      (dec)
    );

    hcmm_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .ready (mem_ready)
    );

    // Handshake: stage one drains into the output register when it is free
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp_ready);
    assign req_ready = mem_ready && (!s1_valid_reg || s1_adv);
    assign accept    = req_valid && req_ready;

    // Issue the memory access for the accepted beat
    always_comb
    begin
        mem_req.re    = accept && dec.use_mem;
        mem_req.we    = accept && dec.mem_we;
        mem_req.idx   = dec.mem_idx;
        mem_req.wdata = req.write_data;
    end

    // Update the mapped registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_off_reg <= hcmm_pkg::BOOT_RESET;
            if_reg       <= hcmm_pkg::IF_RESET;
            ie_reg       <= hcmm_pkg::IE_RESET;
        end
        else if (accept)
        begin
            if (dec.wr_boot)
            begin
                boot_off_reg <= req.write_data;
            end
            if (dec.wr_if)
            begin
                if_reg <= req.write_data | hcmm_pkg::IRQ_FORCE;
            end
            if (dec.wr_ie)
            begin
                ie_reg <= req.write_data | hcmm_pkg::IRQ_FORCE;
            end
        end
    end

    // Advance stage one and the output register
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        rsp_next       = rsp_reg;
        if (s1_adv)
        begin
            s1_valid_next  = 1'b0;
            out_valid_next = 1'b1;
            rsp_next.target_unit = s1_unit_reg;
            if (s1_write_reg)
            begin
                rsp_next.read_data = 8'h00;
            end
            else if (s1_mem_reg)
            begin
                rsp_next.read_data = mem_rdata;
            end
            else
            begin
                rsp_next.read_data = s1_imm_reg;
            end
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payload; no reset needed
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            s1_write_reg <= dec.is_write;
            s1_unit_reg  <= dec.unit;
            s1_mem_reg   <= dec.use_mem;
            s1_imm_reg   <= dec.imm;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/hcmm_checker.sv @@
// Port-level checker for the bus decoder and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcmm_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input hcmm_pkg::req_t  req,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input hcmm_pkg::rsp_t  rsp
);

    logic req_acc;
    logic rsp_stall;
    logic wram_acc;
    logic out_free;
    logic rsp_internal;

    assign req_acc      = req_valid && req_ready;
    assign rsp_stall    = rsp_valid && !rsp_ready;
    assign wram_acc     = req_acc && req.address >= 16'hC000 && req.address < 16'hFE00;
    assign out_free     = !rsp_valid || rsp_ready;
    assign rsp_internal = rsp.target_unit == hcmm_pkg::UNIT_INTERNAL;

    // A stalled response holds its beat
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(rsp))
    // Every accepted request is followed by a response on rsp_valid
    `ASSERT_NEXT(a_rsp_follows, clk, rst_n, req_acc, ##1 rsp_valid)
    // Target codes stay within the defined units
    `ASSERT_IMPLIES(a_unit_range, clk, rst_n, rsp_valid, rsp.target_unit <= hcmm_pkg::UNIT_TIMER)
    // Work RAM beats report the internal unit once they reach the output
    `ASSERT_NEXT(a_wram_internal, clk, rst_n, wram_acc ##1 out_free, rsp_valid && rsp_internal)

endmodule

bind handheld_console_memory_map_top hcmm_checker u_hcmm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
